// ===== sv/ts_pcr_packet_rate_estimator_macros.svh =====
// Assertion macros for the TS PCR packet rate estimator.
// Included by files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef TS_PCR_PACKET_RATE_ESTIMATOR_MACROS_SVH
`define TS_PCR_PACKET_RATE_ESTIMATOR_MACROS_SVH
`ifndef SYNTH
`define TSPRE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TSPRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TSPRE_ASSERT_IMPL(lbl, ante, cons)
`define TSPRE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/tspre_pkg.sv =====
// Shared types and constants of the TS PCR packet rate estimator.
// No dependencies.
package tspre_pkg;

  localparam int CLK_W  = 42;
  localparam int TIME_W = 48;
  localparam int EST_W  = 48;
  localparam int STEP_W = 43;
  localparam int GAPP_W = 47;
  localparam int CFG_IDX_W = 2;

  localparam int unsigned PCR_BASE_MULT = 300;
  localparam int unsigned MS_TICKS      = 27000;

  localparam logic [7:0]  TS_SYNC_BYTE = 8'h47;
  localparam logic [12:0] NULL_PID     = 13'h1FFF;
  localparam logic [7:0]  AF_MIN_LEN   = 8'd7;
  localparam logic [7:0]  CC_CLEAR     = 8'hF0;

  localparam logic [CFG_IDX_W-1:0] CFG_NULL_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYOUT     = 2'd3;

  localparam logic [EST_W-1:0] EST_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [EST_W-1:0] EST_MIN = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    ST_PLAIN    = 4'd0,
    ST_NULL     = 4'd1,
    ST_STAMP    = 4'd2,
    ST_NOSYNC   = 4'd3,
    ST_FIRST    = 4'd4,
    ST_UPDATED  = 4'd5,
    ST_SKIPPED  = 4'd6,
    ST_DISCON   = 4'd7,
    ST_FULL     = 4'd8,
    ST_STOPPED  = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    K_STOP   = 3'd0,
    K_NOSYNC = 3'd1,
    K_NULL   = 3'd2,
    K_STAMP  = 3'd3,
    K_PLAIN  = 3'd4,
    K_PCR    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [12:0]       pid;
    logic [CLK_W-1:0]  first_clock;
    logic [CLK_W-1:0]  last_clock;
    logic [TIME_W-1:0] first_time;
    logic [31:0]       last_index;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    decode;
    logic    scan_rd;
    logic    scan_cmp;
    logic    new_ent;
    logic    prep;
    logic    skipchk;
    logic    div_dur;
    logic    upd;
    logic    adj;
    logic    div_five;
    logic    fin5;
    logic    wr_ent;
    logic    finish;
    status_t code;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  match;
    logic  free_any;
    logic  scan_last;
    logic  skip;
    logic  div_done;
    logic  take_avg;
    logic  shrink;
    logic  discon;
    logic  out_free;
  } sts_t;

endpackage

// ===== sv/tspre_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// No package dependency.
module tspre_div #(
  parameter int DW = 58,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   rem_sh;
  logic [VW+1:0] diff;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DW-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge       = ~diff[VW+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/tspre_ctrl.sv =====
// Controller state machine of the TS PCR packet rate estimator.
// Depends on tspre_pkg; drives the datapath through cmd_t and reads sts_t.
module tspre_ctrl
  import tspre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_DECODE   = 15'h0002,
    S_SCAN_RD  = 15'h0004,
    S_SCAN_CMP = 15'h0008,
    S_NEW      = 15'h0010,
    S_PREP     = 15'h0020,
    S_SKIPCHK  = 15'h0040,
    S_CHECK    = 15'h0080,
    S_DIV      = 15'h0100,
    S_UPD      = 15'h0200,
    S_ADJ      = 15'h0400,
    S_DIV5     = 15'h0800,
    S_FIN5     = 15'h1000,
    S_WRITE    = 15'h2000,
    S_DONE     = 15'h4000
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_DONE;
        case (sts.kind)
          K_STOP:   code_nxt = ST_STOPPED;
          K_NOSYNC: code_nxt = ST_NOSYNC;
          K_NULL:   code_nxt = ST_NULL;
          K_STAMP:  code_nxt = ST_STAMP;
          K_PCR:    state_nxt = S_SCAN_RD;
          default:  code_nxt = ST_PLAIN;
        endcase
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (sts.match) begin
          state_nxt = S_PREP;
        end else if (sts.scan_last) begin
          if (sts.free_any) begin
            state_nxt = S_NEW;
          end else begin
            code_nxt  = ST_FULL;
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_NEW: begin
        cmd.new_ent = 1'b1;
        code_nxt    = ST_FIRST;
        state_nxt   = S_DONE;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_SKIPCHK;
      end
      S_SKIPCHK: begin
        cmd.skipchk = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (sts.skip) begin
          code_nxt  = ST_SKIPPED;
          state_nxt = S_WRITE;
        end else begin
          cmd.div_dur = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        code_nxt  = sts.discon ? ST_DISCON : ST_UPDATED;
        state_nxt = sts.take_avg ? S_ADJ : S_WRITE;
      end
      S_ADJ: begin
        cmd.adj = 1'b1;
        if (sts.shrink) begin
          cmd.div_five = 1'b1;
          state_nxt    = S_DIV5;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_DIV5: begin
        if (sts.div_done) begin
          state_nxt = S_FIN5;
        end
      end
      S_FIN5: begin
        cmd.fin5  = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_ent = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.code = code_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_PLAIN;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== sv/tspre_dp.sv =====
// Datapath of the TS PCR packet rate estimator: counters, PID table, estimate.
// Depends on tspre_pkg and tspre_div; driven by tspre_ctrl through cmd_t.
module tspre_dp
  import tspre_pkg::*;
#(
  parameter int PCR_PIDS      = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_wdata,
  input  logic                  in_action,
  input  logic [31:0]           in_header_bytes,
  input  logic [63:0]           in_body_bytes,
  input  logic [TIME_W-1:0]     in_time_now,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_status,
  output logic [EST_W-1:0]      out_duration_estimate,
  output logic [7:0]            out_byte3_out
);

  localparam int IW = (PCR_PIDS > 1) ? $clog2(PCR_PIDS) : 1;
  localparam int DW = CLK_W + FRACTION_BITS;

  logic [7:0]  marker_r;
  logic [31:0] jump_r, nlimit_r, margin_r;

  logic              action_r;
  logic [31:0]       hdr_r;
  logic [63:0]       body_r;
  logic [TIME_W-1:0] now_r;

  logic [31:0]       pt_r, pcr_r, gap_r;
  logic [EST_W-1:0]  est_r, est_nxt;
  logic [PCR_PIDS-1:0] valid_r;
  logic [IW-1:0]     idx_r, free_idx_r;
  logic              free_found_r;

  logic [CLK_W-1:0]  clock_r;
  logic [GAPP_W-1:0] gap_prod_r;
  logic              discon_r;
  logic [STEP_W-1:0] step_r;
  logic [31:0]       n_r, d_r;
  logic [CLK_W-1:0]  mag_r;
  logic              neg_r;
  logic              a_lt_r;
  logic [63:0]       prod_r;
  logic              shrink_r, grow_r;
  logic [7:0]        b3_r;
  entry_t            ent_r, rd_r, new_ent;

  entry_t            mem [PCR_PIDS];
  logic              mem_we;
  logic [IW-1:0]     mem_addr;
  entry_t            mem_wdata;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [EST_W-1:0]  out_est_r;
  logic [7:0]        out_b3_r;

  logic [EST_W+1:0]  d5_n_r, d5_q_r, d5_rem_r;
  logic [2:0]        d5_cnt_r;
  logic              d5_done_r;
  logic [1:0]        d5_fix;

  logic [7:0]        byte0, byte3;
  logic [12:0]       pid;
  logic [31:0]       gap_in;
  logic [CLK_W-1:0]  pcr_clock;
  kind_t             kind;
  logic              match;
  logic [TIME_W:0]   ft_sum;
  logic [STEP_W-1:0] step_new;
  logic [32:0]       a33;
  logic              step_big;
  logic              skip;
  logic              div_start;
  logic [DW-1:0]     div_dvd;
  logic [31:0]       div_dvs;
  logic              div_done;
  logic [DW-1:0]     quo;
  logic              dur_sat;
  logic [EST_W-1:0]  dur;
  logic              take_avg;
  logic signed [EST_W:0] avg_sum, avg_adj;
  logic [EST_W:0]    tr;
  logic [STEP_W-1:0] pl;
  logic              tr_gt_pl, trm_lt_pl;
  logic signed [EST_W+1:0] trm;
  logic [EST_W-1:0]  est_mag;
  logic [EST_W+1:0]  m5;
  logic [EST_W-1:0]  q5;

  assign byte0     = hdr_r[31:24];
  assign byte3     = hdr_r[7:0];
  assign pid       = hdr_r[20:8];
  assign gap_in    = {body_r[39:32], body_r[47:40], body_r[55:48], body_r[63:56]};
  assign pcr_clock = CLK_W'(body_r[47:15]) * CLK_W'(PCR_BASE_MULT) + CLK_W'(body_r[8:0]);

  always_comb begin
    if (action_r) begin
      kind = K_STOP;
    end else if (byte0 != TS_SYNC_BYTE) begin
      kind = K_NOSYNC;
    end else if (pid == NULL_PID) begin
      kind = (byte3 == marker_r) ? K_STAMP : K_NULL;
    end else if (byte3[5] && body_r[63:56] >= AF_MIN_LEN && body_r[52]) begin
      kind = K_PCR;
    end else begin
      kind = K_PLAIN;
    end
  end

  assign match    = valid_r[idx_r] && (rd_r.pid == pid);
  assign ft_sum   = {1'b0, rd_r.first_time} + {2'b00, gap_prod_r};
  assign step_new = {1'b0, clock_r} - {1'b0, rd_r.last_clock};
  assign a33      = {n_r, 1'b0};
  assign step_big = !step_r[STEP_W-1] && (step_r[CLK_W-1:0] > CLK_W'(jump_r));
  assign skip     = !discon_r && (pcr_r != 32'd0) && a_lt_r && (prod_r < {32'd0, pt_r});

  assign est_mag = est_r[EST_W-1] ? (~est_r + 48'd1) : est_r;

  always_comb begin
    dur_sat = |quo[DW-1:EST_W-1];
    if (dur_sat) begin
      dur = neg_r ? EST_MIN : EST_MAX;
    end else if (neg_r) begin
      dur = ~{1'b0, quo[EST_W-2:0]} + 48'd1;
    end else begin
      dur = {1'b0, quo[EST_W-2:0]};
    end
    take_avg  = (est_r != '0) && !discon_r && !dur[EST_W-1];
    avg_sum   = $signed({dur[EST_W-1], dur}) + $signed({est_r[EST_W-1], est_r});
    avg_adj   = avg_sum + $signed({{EST_W{1'b0}}, avg_sum[EST_W]});
    tr        = {1'b0, now_r} - {1'b0, ent_r.first_time};
    pl        = {1'b0, clock_r} - {1'b0, ent_r.first_clock};
    tr_gt_pl  = $signed(tr) > $signed({{(EST_W+1-STEP_W){pl[STEP_W-1]}}, pl});
    trm       = $signed({tr[EST_W], tr}) + $signed({18'd0, margin_r});
    trm_lt_pl = trm < $signed({{(EST_W+2-STEP_W){pl[STEP_W-1]}}, pl});
    m5        = {est_mag, 2'b00} + {2'b00, est_mag};
    q5        = m5[EST_W+1:2];
  end

  always_comb begin
    div_start = cmd.div_dur;
    div_dvd   = {mag_r, {FRACTION_BITS{1'b0}}};
    div_dvs   = d_r;
  end

  tspre_div #(
    .DW (DW),
    .VW (32)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // Division of four times the estimate magnitude by five: a shift-add reciprocal,
  // then a remainder correction.
  always_comb begin
    if (d5_rem_r >= (EST_W+2)'(15)) begin
      d5_fix = 2'd3;
    end else if (d5_rem_r >= (EST_W+2)'(10)) begin
      d5_fix = 2'd2;
    end else if (d5_rem_r >= (EST_W+2)'(5)) begin
      d5_fix = 2'd1;
    end else begin
      d5_fix = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d5_cnt_r  <= '0;
      d5_done_r <= 1'b0;
    end else begin
      d5_done_r <= 1'b0;
      if (cmd.div_five) begin
        d5_n_r   <= {est_mag, 2'b00};
        d5_q_r   <= {1'b0, est_mag, 1'b0} + {2'b00, est_mag};
        d5_cnt_r <= 3'd7;
      end else if (d5_cnt_r != 3'd0) begin
        d5_cnt_r <= d5_cnt_r - 3'd1;
        case (d5_cnt_r)
          3'd7:    d5_q_r   <= d5_q_r + (d5_q_r >> 4);
          3'd6:    d5_q_r   <= d5_q_r + (d5_q_r >> 8);
          3'd5:    d5_q_r   <= d5_q_r + (d5_q_r >> 16);
          3'd4:    d5_q_r   <= d5_q_r + (d5_q_r >> 32);
          3'd3:    d5_q_r   <= d5_q_r >> 2;
          3'd2:    d5_rem_r <= d5_n_r - ({d5_q_r[EST_W-1:0], 2'b00} + d5_q_r);
          3'd1: begin
            d5_q_r    <= d5_q_r + {{EST_W{1'b0}}, d5_fix};
            d5_done_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    est_nxt = est_r;
    if (cmd.upd) begin
      if (est_r == '0) begin
        est_nxt = dur;
      end else if (take_avg) begin
        est_nxt = avg_adj[EST_W:1];
      end
    end else if (cmd.adj && grow_r && !shrink_r) begin
      if (!est_r[EST_W-1]) begin
        est_nxt = q5[EST_W-1] ? EST_MAX : q5;
      end else begin
        est_nxt = (q5[EST_W-1] && (q5[EST_W-2:0] != '0)) ? EST_MIN : (~q5 + 48'd1);
      end
    end else if (cmd.fin5) begin
      est_nxt = est_r[EST_W-1] ? (~d5_q_r[EST_W-1:0] + 48'd1) : d5_q_r[EST_W-1:0];
    end
  end

  always_comb begin
    new_ent.pid         = pid;
    new_ent.first_clock = clock_r;
    new_ent.last_clock  = clock_r;
    new_ent.first_time  = now_r;
    new_ent.last_index  = pt_r;
    mem_we    = cmd.new_ent || cmd.wr_ent;
    mem_addr  = cmd.new_ent ? free_idx_r : idx_r;
    mem_wdata = cmd.new_ent ? new_ent : ent_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.scan_rd) begin
      rd_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r     <= 8'hFF;
      jump_r       <= 32'd6750000;
      nlimit_r     <= 32'd250;
      margin_r     <= 32'd2700000;
      pt_r         <= '0;
      pcr_r        <= '0;
      gap_r        <= '0;
      est_r        <= '0;
      valid_r      <= '0;
      idx_r        <= '0;
      free_idx_r   <= '0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_NULL_MARKER: marker_r <= cfg_wdata[7:0];
          CFG_JUMP_LIMIT:  jump_r   <= cfg_wdata;
          CFG_NULL_LIMIT:  nlimit_r <= cfg_wdata;
          CFG_PLAYOUT:     margin_r <= cfg_wdata;
          default: ;
        endcase
      end
      est_r <= est_nxt;
      if (cmd.decode) begin
        idx_r        <= '0;
        free_found_r <= 1'b0;
        case (kind)
          K_STOP: begin
            pt_r    <= '0;
            pcr_r   <= '0;
            gap_r   <= '0;
            valid_r <= '0;
          end
          K_STAMP: gap_r <= gap_in;
          K_PLAIN: pt_r  <= pt_r + 32'd1;
          K_PCR: begin
            pt_r  <= pt_r + 32'd1;
            pcr_r <= pcr_r + 32'd1;
          end
          default: ;
        endcase
      end
      if (cmd.scan_cmp && !match) begin
        if (!valid_r[idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= idx_r;
        end
        if (!sts.scan_last) begin
          idx_r <= idx_r + IW'(1);
        end
      end
      if (cmd.new_ent) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.prep) begin
        gap_r <= '0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      hdr_r    <= in_header_bytes;
      body_r   <= in_body_bytes;
      now_r    <= in_time_now;
    end
    if (cmd.decode) begin
      clock_r    <= pcr_clock;
      discon_r   <= body_r[55];
      gap_prod_r <= GAPP_W'(gap_r) * GAPP_W'(MS_TICKS);
      if (kind == K_STOP) begin
        b3_r <= 8'h00;
      end else if (kind == K_STAMP) begin
        b3_r <= byte3 & CC_CLEAR;
      end else begin
        b3_r <= byte3;
      end
    end
    if (cmd.prep) begin
      ent_r.pid         <= rd_r.pid;
      ent_r.first_clock <= rd_r.first_clock;
      ent_r.last_clock  <= rd_r.last_clock;
      ent_r.first_time  <= ft_sum[TIME_W] ? {TIME_W{1'b1}} : ft_sum[TIME_W-1:0];
      ent_r.last_index  <= rd_r.last_index;
      step_r            <= step_new;
      n_r               <= pt_r - rd_r.last_index;
      if (gap_r > nlimit_r) begin
        discon_r <= 1'b1;
      end
    end
    if (cmd.skipchk) begin
      if (step_r[STEP_W-1] || step_big) begin
        discon_r <= 1'b1;
      end
      neg_r  <= step_r[STEP_W-1];
      mag_r  <= step_r[STEP_W-1] ? (~step_r[CLK_W-1:0] + CLK_W'(1)) : step_r[CLK_W-1:0];
      d_r    <= (n_r == 32'd0) ? 32'd1 : n_r;
      a_lt_r <= a33 < {1'b0, pt_r};
      prod_r <= {32'd0, a33[31:0]} * {32'd0, pcr_r};
    end
    if (cmd.upd) begin
      ent_r.last_clock <= clock_r;
      ent_r.last_index <= pt_r;
      if (est_r != '0 && !take_avg) begin
        ent_r.first_clock <= clock_r;
        ent_r.first_time  <= now_r;
      end
      shrink_r <= !tr[EST_W] && (tr != '0) && !pl[STEP_W-1] && (pl != '0) && tr_gt_pl;
      grow_r   <= !tr[EST_W] && (tr != '0) && !pl[STEP_W-1] && (pl != '0) && !tr_gt_pl
                  && trm_lt_pl;
    end
    if (cmd.finish) begin
      out_status_r <= cmd.code;
      out_est_r    <= est_r;
      out_b3_r     <= b3_r;
    end
  end

  always_comb begin
    sts.kind      = kind;
    sts.match     = match;
    sts.free_any  = free_found_r || !valid_r[idx_r];
    sts.scan_last = (idx_r == IW'(PCR_PIDS - 1));
    sts.skip      = skip;
    sts.div_done  = div_done || d5_done_r;
    sts.take_avg  = take_avg;
    sts.shrink    = shrink_r;
    sts.discon    = discon_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_duration_estimate = out_est_r;
  assign out_byte3_out         = out_b3_r;

endmodule

// ===== sv/ts_pcr_packet_rate_estimator.sv =====
// TS PCR packet rate estimator top level: controller plus datapath, one beat at a time.
// A stop, null or plain beat is only decoded; a PCR beat also scans the table entries and
// may run the serial divider and, when the estimate shrinks, a 4/5 drift correction.
// A new beat is taken once the previous one is in the output register.
// Reset is synchronous: counters, estimate, table valid bits and registers return to defaults.
`include "ts_pcr_packet_rate_estimator_macros.svh"
module ts_pcr_packet_rate_estimator
  import tspre_pkg::*;
#(
  parameter int PCR_PIDS      = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [31:0]          in_header_bytes,
  input  logic [63:0]          in_body_bytes,
  input  logic [47:0]          in_time_now,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_status,
  output logic signed [47:0]   out_duration_estimate,
  output logic [7:0]           out_byte3_out
);

  cmd_t cmd;
  sts_t sts;
  logic [47:0] est_bits;

  tspre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tspre_dp #(
    .PCR_PIDS      (PCR_PIDS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_action             (in_action),
    .in_header_bytes       (in_header_bytes),
    .in_body_bytes         (in_body_bytes),
    .in_time_now           (in_time_now),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_duration_estimate (est_bits),
    .out_byte3_out         (out_byte3_out)
  );

  assign out_duration_estimate = $signed(est_bits);

  `TSPRE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `TSPRE_ASSERT_IMPL(a_status_range, out_valid, out_status <= ST_STOPPED)
  `TSPRE_ASSERT_IMPL(a_stop_byte3, out_valid && out_status == ST_STOPPED, out_byte3_out == 8'h00)
  `TSPRE_ASSERT_IMPL(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule
